/* design/psng_pkg.sv */
`default_nettype none

package psng_pkg;

  // generator constants (ansi c lcg)
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;

  // q1.14 scaling: 0.1 * 2^14 rounded down, and 1.0
  localparam logic [10:0]        NOISE_GAIN = 11'd1638;
  localparam logic [12:0]        NOISE_BIAS = 13'd1638;
  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic signed [15:0] MINUS_ONE_Q14 = -16'sd16384;

  // configuration register indexes
  localparam logic [1:0] CFG_SEED          = 2'd0;
  localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;
  localparam logic [1:0] CFG_PHASE_LENGTH  = 2'd2;
  localparam logic [1:0] CFG_TOTAL_STEPS   = 2'd3;

  // microprogram addresses
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] U_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] U_SGN_MUL  = 4'd2;
  localparam logic [UPC_W-1:0] U_SGN_ADD  = 4'd3;
  localparam logic [UPC_W-1:0] U_SGN_WR   = 4'd4;
  localparam logic [UPC_W-1:0] U_NZ_MUL   = 4'd5;
  localparam logic [UPC_W-1:0] U_NZ_ADD   = 4'd6;
  localparam logic [UPC_W-1:0] U_NZ_SCALE = 4'd7;
  localparam logic [UPC_W-1:0] U_NZ_EMIT  = 4'd8;
  localparam logic [UPC_W-1:0] U_STEP_END = 4'd9;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NOT_GO,
    JC_PHASE_RUN,
    JC_MORE
  } psng_jcond_e;

  typedef struct packed {
    logic             prod_en;
    logic             gen_en;
    logic             scale_en;
    logic             sign_wr;
    logic             emit;
    logic             wait_out;
    logic             comp_adv;
    logic             step_upd;
    psng_jcond_e      cond;
    logic [UPC_W-1:0] target;
  } psng_uword_t;

  typedef struct packed {
    logic load_seed;
    logic prod_en;
    logic gen_en;
    logic scale_en;
  } psng_dp_ctrl_t;

  function automatic psng_uword_t psng_ucode(input logic [UPC_W-1:0] addr);
    psng_uword_t w;
    w        = '0;
    w.cond   = JC_NEXT;
    w.target = U_IDLE;
    case (addr)
      U_IDLE: begin
        w.cond   = JC_NOT_GO;
        w.target = U_IDLE;
      end
      U_DISPATCH: begin
        // signs are redrawn only on the first step of a phase
        w.cond   = JC_PHASE_RUN;
        w.target = U_NZ_MUL;
      end
      U_SGN_MUL: w.prod_en = 1'b1;
      U_SGN_ADD: w.gen_en  = 1'b1;
      U_SGN_WR: begin
        w.sign_wr  = 1'b1;
        w.comp_adv = 1'b1;
        w.cond     = JC_MORE;
        w.target   = U_SGN_MUL;
      end
      U_NZ_MUL:   w.prod_en  = 1'b1;
      U_NZ_ADD:   w.gen_en   = 1'b1;
      U_NZ_SCALE: w.scale_en = 1'b1;
      U_NZ_EMIT: begin
        w.emit     = 1'b1;
        w.wait_out = 1'b1;
        w.comp_adv = 1'b1;
        w.cond     = JC_MORE;
        w.target   = U_NZ_MUL;
      end
      U_STEP_END: begin
        w.step_upd = 1'b1;
        w.cond     = JC_ALWAYS;
        w.target   = U_IDLE;
      end
      default: begin
        w.cond   = JC_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/psng_datapath.sv */
`default_nettype none

module psng_datapath (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  psng_pkg::psng_dp_ctrl_t ctrl_i,
  input  wire  [31:0]             seed_i,
  output logic                    draw_sign_o,
  output logic signed [11:0]      noise_o
);

  logic [31:0] gen_q, gen_d;
  logic [31:0] prod_q;
  logic [11:0] scale_q;
  logic [31:0] twom1;
  logic [42:0] scale_full;
  logic [12:0] noise_wide;

  // low word of the lcg product; the increment is added in the following cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      prod_q <= gen_q * psng_pkg::LCG_MUL;
    end
  end

  always_comb begin
    gen_d = gen_q;
    if (ctrl_i.load_seed) begin
      gen_d = seed_i;
    end else if (ctrl_i.gen_en) begin
      gen_d = prod_q + psng_pkg::LCG_INC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else begin
      gen_q <= gen_d;
    end
  end

  // (2m + 1) * 1638 >> 31, kept unsigned; NOISE_BIAS is subtracted after the register
  assign twom1      = {gen_q[30:0], 1'b1};
  assign scale_full = 43'(twom1) * 43'(psng_pkg::NOISE_GAIN);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scale_en) begin
      scale_q <= scale_full[42:31];
    end
  end

  assign noise_wide  = {1'b0, scale_q} - psng_pkg::NOISE_BIAS;
  assign noise_o     = noise_wide[11:0];
  assign draw_sign_o = gen_q[30];

endmodule

`default_nettype wire

/* design/phased_sign_noise_generator_core.sv */
`default_nettype none

// Phased sign noise generator. Each input item (a tick) yields one result item per
// component of the vector, each a Q1.14 value sign*1.0 + noise clamped to +-1.0, from
// a 32-bit ANSI C style LCG. A tick with restart high reloads the seed and clears the
// step and phase counts first; ticks after total_steps steps give no result. A small
// microprogram drives one shared multiply/add generator, and every draw is a
// multiply step followed by an add step. The signs are redrawn on the first step
// of each phase, before the noise draws; a tick past the end of the sequence is
// taken without starting the microprogram. Output stalls hold the emit step.
// Input stall is high while a tick is being worked on.
module phased_sign_noise_generator_core #(
  parameter int unsigned MAX_COMPONENTS = 16,
  localparam int unsigned CompW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
  localparam int unsigned NW    = $clog2(MAX_COMPONENTS + 1),
  localparam int unsigned CntW  = (NW > 5) ? NW : 5
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [1:0]         cfg_idx_i,
  input  wire  [31:0]        cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                restart_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [15:0] value_o,
  output logic [CompW-1:0]   component_o,
  output logic [30:0]        step_index_o,
  output logic               last_of_step_o,
  output logic               last_of_sequence_o
);

  // configuration registers
  logic [31:0] seed_q;
  logic [4:0]  vlen_q;
  logic [15:0] plen_q;
  logic [30:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      vlen_q  <= 5'd1;
      plen_q  <= 16'd1;
      total_q <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psng_pkg::CFG_SEED:          seed_q  <= cfg_data_i;
        psng_pkg::CFG_VECTOR_LENGTH: vlen_q  <= cfg_data_i[4:0];
        psng_pkg::CFG_PHASE_LENGTH:  plen_q  <= cfg_data_i[15:0];
        psng_pkg::CFG_TOTAL_STEPS:   total_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [psng_pkg::UPC_W-1:0] upc_q, upc_d;
  psng_pkg::psng_uword_t      uw;
  psng_pkg::psng_dp_ctrl_t    dp_ctrl;

  logic              in_acc, go, active, hold, fire, cond_true;
  logic [30:0]       eff_step;
  logic [31:0]       eff_step_p1;
  logic [30:0]       step_q, step_d;
  logic [15:0]       phase_q, phase_d, phase_p1, plen_eff;
  logic [CntW-1:0]   n_q, n_sat, vlen_ext;
  logic              final_q;
  logic [CompW-1:0]  comp_q, comp_d;
  logic              comp_last;

  logic              sign_mem [MAX_COMPONENTS];
  logic              sign_rd_q;
  logic              draw_sign;
  logic signed [11:0] noise;
  logic signed [15:0] base, sum, clamped;

  logic              out_valid_q;
  logic signed [15:0] value_q;
  logic [CompW-1:0]  component_q;
  logic [30:0]       step_index_q;
  logic              last_step_q, last_seq_q;

  assign uw         = psng_pkg::psng_ucode(upc_q);
  assign in_stall_o = (upc_q != psng_pkg::U_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign eff_step    = restart_i ? 31'd0 : step_q;
  assign eff_step_p1 = {1'b0, eff_step} + 32'd1;
  assign active      = (eff_step < total_q);
  assign go          = in_acc && active;

  assign hold = uw.wait_out && out_valid_q && out_stall_i;
  assign fire = !hold;

  assign comp_last = ((CntW'(comp_q) + CntW'(1)) == n_q);

  always_comb begin
    case (uw.cond)
      psng_pkg::JC_NEXT:      cond_true = 1'b0;
      psng_pkg::JC_ALWAYS:    cond_true = 1'b1;
      psng_pkg::JC_NOT_GO:    cond_true = !go;
      psng_pkg::JC_PHASE_RUN: cond_true = (phase_q != 16'd0);
      psng_pkg::JC_MORE:      cond_true = !comp_last;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_d = upc_q;
    end else if (cond_true) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + psng_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= psng_pkg::U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // clamp vector length to 1..MAX_COMPONENTS
  assign vlen_ext = CntW'(vlen_q);
  always_comb begin
    n_sat = vlen_ext;
    if (vlen_ext == '0) begin
      n_sat = CntW'(1);
    end else if (vlen_ext > CntW'(MAX_COMPONENTS)) begin
      n_sat = CntW'(MAX_COMPONENTS);
    end
  end

  assign plen_eff = (plen_q == 16'd0) ? 16'd1 : plen_q;
  assign phase_p1 = phase_q + 16'd1;

  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    if (in_acc && restart_i) begin
      step_d  = '0;
      phase_d = '0;
    end else if (uw.step_upd) begin
      step_d  = step_q + 31'd1;
      phase_d = (phase_p1 >= plen_eff) ? 16'd0 : phase_p1;
    end
  end

  always_comb begin
    comp_d = comp_q;
    if (go) begin
      comp_d = '0;
    end else if (uw.comp_adv && fire) begin
      comp_d = comp_last ? '0 : comp_q + CompW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      phase_q <= '0;
      comp_q  <= '0;
      n_q     <= CntW'(1);
      final_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      phase_q <= phase_d;
      comp_q  <= comp_d;
      if (go) begin
        n_q     <= n_sat;
        final_q <= (eff_step_p1 == {1'b0, total_q});
      end
    end
  end

  assign dp_ctrl.load_seed = in_acc && restart_i;
  assign dp_ctrl.prod_en   = uw.prod_en && fire;
  assign dp_ctrl.gen_en    = uw.gen_en && fire;
  assign dp_ctrl.scale_en  = uw.scale_en && fire;

  psng_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dp_ctrl),
    .seed_i      (seed_q),
    .draw_sign_o (draw_sign),
    .noise_o     (noise)
  );

  // per-component sign, 1 means +1
  always_ff @(posedge clk_i) begin
    if (uw.sign_wr) begin
      sign_mem[comp_q] <= draw_sign;
    end
    sign_rd_q <= sign_mem[comp_q];
  end

  assign base = sign_rd_q ? psng_pkg::ONE_Q14 : psng_pkg::MINUS_ONE_Q14;
  assign sum  = base + {{4{noise[11]}}, noise};

  always_comb begin
    clamped = sum;
    if (sum > psng_pkg::ONE_Q14) begin
      clamped = psng_pkg::ONE_Q14;
    end else if (sum < psng_pkg::MINUS_ONE_Q14) begin
      clamped = psng_pkg::MINUS_ONE_Q14;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.emit && fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.emit && fire) begin
      value_q      <= clamped;
      component_q  <= comp_q;
      step_index_q <= step_q;
      last_step_q  <= comp_last;
      last_seq_q   <= comp_last && final_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign value_o            = value_q;
  assign component_o        = component_q;
  assign step_index_o       = step_index_q;
  assign last_of_step_o     = last_step_q;
  assign last_of_sequence_o = last_seq_q;

  // component index stays inside the vector while a tick is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q != psng_pkg::U_IDLE) |-> (CntW'(comp_q) < n_q))
    else $error("component index beyond vector length");

  // end of sequence only ever marks the end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_seq_q) |-> last_step_q)
    else $error("last_of_sequence without last_of_step");

  // step count moves only at a restart or at the end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && (upc_q != psng_pkg::U_STEP_END)) |=> $stable(step_q))
    else $error("step count changed mid-step");

endmodule

`default_nettype wire
